[design/utl_pkg.sv]
// Shared types, constants and the UTF-8 decode function of the text cursor layout block.
package utl_pkg;

    // Default cell geometry and queue size
    localparam int CELL_WIDTH_DFLT  = 6;
    localparam int CELL_HEIGHT_DFLT = 8;
    localparam int QUEUE_DEPTH_DFLT = 4;

    // Most code points one byte can release (truncated sequence flush)
    localparam int MAX_CP = 3;
    localparam int CP_W   = 21;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WRAP_LIMIT = 8'd0,
        REG_SCALE      = 8'd1,
        REG_FG_COLOR   = 8'd2,
        REG_BG_COLOR   = 8'd3
    } t_reg_index;

    // Draw command kinds
    typedef enum logic [1:0] {
        KIND_GLYPH = 2'd0,
        KIND_BOX   = 2'd1,
        KIND_BLANK = 2'd2,
        KIND_BREAK = 2'd3
    } t_kind;

    // Special code points
    localparam logic [CP_W-1:0] CP_LF       = 21'h00000A;
    localparam logic [CP_W-1:0] CP_CR       = 21'h00000D;
    localparam logic [CP_W-1:0] CP_PRINT_LO = 21'h000020;
    localparam logic [CP_W-1:0] CP_PRINT_HI = 21'h000080;

    // Lead byte classes
    localparam logic [7:0] LEAD_ASCII_LIM = 8'h80;
    localparam logic [7:0] LEAD2_MASK     = 8'hE0;
    localparam logic [7:0] LEAD2_PAT      = 8'hC0;
    localparam logic [7:0] LEAD3_MASK     = 8'hF0;
    localparam logic [7:0] LEAD3_PAT      = 8'hE0;
    localparam logic [7:0] LEAD4_MASK     = 8'hF8;
    localparam logic [7:0] LEAD4_PAT      = 8'hF0;

    // Input word
    typedef struct packed {
        logic [7:0]         in_byte;
        logic               first;
        logic               final_byte;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
    } t_in_word;

    // Output word
    typedef struct packed {
        t_kind              kind;
        logic [CP_W-1:0]    code_point;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [10:0]        cell_w;
        logic [10:0]        cell_h;
        logic [15:0]        line_count;
        logic               end_of_string;
    } t_out_word;

    // Decoded group handed from front to back through the queue
    typedef struct packed {
        logic                       first;
        logic                       final_byte;
        logic signed [15:0]         start_x;
        logic signed [15:0]         start_y;
        logic [1:0]                 count;
        logic [MAX_CP-1:0][CP_W-1:0] cp;
    } t_cp_group;

    typedef struct packed {
        logic [1:0]                 count;
        logic [MAX_CP-1:0][CP_W-1:0] cp;
    } t_decoded;

    // Continuation bytes a lead byte calls for; zero for single bytes
    function automatic logic [1:0] f_lead_need(input logic [7:0] c);
        logic [1:0] need;
        need = 2'd0;
        if (c < LEAD_ASCII_LIM)            need = 2'd0;
        else if ((c & LEAD2_MASK) == LEAD2_PAT) need = 2'd1;
        else if ((c & LEAD3_MASK) == LEAD3_PAT) need = 2'd2;
        else if ((c & LEAD4_MASK) == LEAD4_PAT) need = 2'd3;
        return need;
    endfunction

    // Decode n bytes (1..4); a sequence running past the end yields its lead byte
    function automatic t_decoded f_decode(input logic [3:0][7:0] b, input logic [2:0] n);
        t_decoded        r;
        logic [2:0]      pos;
        logic [7:0]      c;
        logic [1:0]      need;
        logic [CP_W-1:0] cp;
        r   = '0;
        pos = 3'd0;
        for (int i = 0; i < MAX_CP; i++) begin
            if (pos < n) begin
                c    = b[pos[1:0]];
                need = f_lead_need(c);
                cp   = {13'd0, c};
                pos  = pos + 3'd1;
                if (need != 2'd0 && ({1'b0, pos} + {2'b00, need}) <= {1'b0, n}) begin
                    case (need)
                        2'd1:    cp = {16'd0, c[4:0]};
                        2'd2:    cp = {17'd0, c[3:0]};
                        default: cp = {18'd0, c[2:0]};
                    endcase
                    for (int j = 0; j < 3; j++) begin
                        if (j < int'(need)) begin
                            cp  = {cp[CP_W-7:0], b[pos[1:0]][5:0]};
                            pos = pos + 3'd1;
                        end
                    end
                end
                r.cp[i] = cp;
                r.count = r.count + 2'd1;
            end
        end
        return r;
    endfunction

endpackage

[design/utl_front.sv]
// Front end: takes bytes, holds partial UTF-8 sequences and emits decoded code point groups.
module utl_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  utl_pkg::t_in_word    i_in_word,
    input  logic                 i_q_ready,
    output logic                 o_push,
    output utl_pkg::t_cp_group   o_group
);

    logic [2:0][7:0] r_held;
    logic [1:0]      r_held_count;
    logic [1:0]      r_need;
    logic [1:0]      n_held_count;
    logic [1:0]      n_need;

    logic            accept;
    logic [1:0]      hc;
    logic [1:0]      need;
    logic [2:0]      n_bytes;
    logic            hold;
    logic [3:0][7:0] buf_bytes;
    utl_pkg::t_decoded dec;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;

    // Byte assembly and decode
    always_comb begin
        hc      = i_in_word.first ? 2'd0 : r_held_count;
        need    = (hc == 2'd0) ? utl_pkg::f_lead_need(i_in_word.in_byte) : r_need;
        n_bytes = {1'b0, hc} + 3'd1;
        hold    = !i_in_word.final_byte && (n_bytes < ({1'b0, need} + 3'd1));
        for (int i = 0; i < 3; i++) begin
            if (i < int'(hc))       buf_bytes[i] = r_held[i];
            else if (i == int'(hc)) buf_bytes[i] = i_in_word.in_byte;
            else                    buf_bytes[i] = 8'd0;
        end
        buf_bytes[3] = (hc == 2'd3) ? i_in_word.in_byte : 8'd0;
        dec = utl_pkg::f_decode(buf_bytes, n_bytes);
    end

    // Group toward the queue; a held first byte still carries the origin
    always_comb begin
        o_push             = accept && (!hold || i_in_word.first);
        o_group.first      = i_in_word.first;
        o_group.final_byte = i_in_word.final_byte;
        o_group.start_x    = i_in_word.start_x;
        o_group.start_y    = i_in_word.start_y;
        o_group.count      = hold ? 2'd0 : dec.count;
        o_group.cp         = dec.cp;
    end

    // Hold state next values
    always_comb begin
        n_held_count = r_held_count;
        n_need       = r_need;
        if (accept) begin
            if (hold) begin
                n_held_count = hc + 2'd1;
                if (hc == 2'd0) n_need = need;
            end else begin
                n_held_count = 2'd0;
                n_need       = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
            r_need       <= 2'd0;
        end else begin
            r_held_count <= n_held_count;
            r_need       <= n_need;
        end
    end

    // Held bytes, payload only
    always_ff @(posedge i_clk) begin
        if (accept && hold && hc != 2'd3) begin
            r_held[hc] <= i_in_word.in_byte;
        end
    end

endmodule

[design/utl_queue.sv]
// Small register queue of decoded groups between front and back.
module utl_queue #(
    parameter int DEPTH = utl_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  utl_pkg::t_cp_group   i_group,
    output logic                 o_ready,
    output logic                 o_head_valid,
    output utl_pkg::t_cp_group   o_head,
    input  logic                 i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    utl_pkg::t_cp_group r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_ready      = (r_count != FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_ready;
    assign do_pop       = i_pop && o_head_valid;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_ONE;
        if (do_pop)  n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_ONE;
        if (do_push && !do_pop)      n_count = r_count + CNT_ONE;
        else if (!do_push && do_pop) n_count = r_count - CNT_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

endmodule

[design/utl_back.sv]
// Back end: lays out one code point per cycle unless its output stalls; tracks cursor and lines.
module utl_back #(
    parameter int CELL_WIDTH  = utl_pkg::CELL_WIDTH_DFLT,
    parameter int CELL_HEIGHT = utl_pkg::CELL_HEIGHT_DFLT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  utl_pkg::t_cp_group   i_head,
    output logic                 o_pop,
    input  logic [14:0]          i_wrap_limit,
    input  logic [7:0]           i_scale,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output utl_pkg::t_out_word   o_out_word
);

    localparam int MAX_CELL = (CELL_WIDTH > CELL_HEIGHT) ? CELL_WIDTH : CELL_HEIGHT;
    localparam int SZ_W     = $clog2(MAX_CELL * 255 + 1);

    // Saturating add of a cell size to a signed coordinate
    function automatic logic signed [15:0] f_sat_add(input logic signed [15:0] a,
                                                     input logic [SZ_W-1:0] d);
        logic signed [17:0] s;
        s = {{2{a[15]}}, a} + 18'(d);
        if (s > 18'sd32767) return 16'sh7FFF;
        return s[15:0];
    endfunction

    function automatic logic [10:0] f_sat11(input logic [SZ_W-1:0] v);
        if (v > SZ_W'(2047)) return 11'h7FF;
        return 11'(v);
    endfunction

    logic signed [15:0] r_origin_x;
    logic signed [15:0] r_cur_x;
    logic signed [15:0] r_cur_y;
    logic [15:0]        r_lines;
    logic [1:0]         r_idx;
    logic               r_out_valid;
    utl_pkg::t_out_word r_out_word;

    logic signed [15:0] n_origin_x;
    logic signed [15:0] n_cur_x;
    logic signed [15:0] n_cur_y;
    logic [15:0]        n_lines;
    logic [1:0]         n_idx;
    logic               n_out_valid;
    utl_pkg::t_out_word n_out_word;

    logic               adv;
    logic               first_now;
    logic               last;
    logic signed [15:0] eff_ox;
    logic signed [15:0] eff_cx;
    logic signed [15:0] eff_cy;
    logic [15:0]        eff_lines;
    logic [SZ_W-1:0]    cw;
    logic [SZ_W-1:0]    lh;
    logic [utl_pkg::CP_W-1:0] cp;
    logic signed [17:0] sum_x;
    logic               is_lf;
    logic               wrap_hit;
    logic signed [15:0] y_bump;
    logic [15:0]        lines_bump;
    logic signed [15:0] px;
    logic signed [15:0] py;
    utl_pkg::t_kind     kind;

    assign cw = SZ_W'(CELL_WIDTH) * SZ_W'(i_scale);
    assign lh = SZ_W'(CELL_HEIGHT) * SZ_W'(i_scale);

    assign adv         = i_head_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Effective layout state, origin taken from the group at a string start
    always_comb begin
        first_now = i_head.first && (r_idx == 2'd0);
        eff_ox    = first_now ? i_head.start_x : r_origin_x;
        eff_cx    = first_now ? i_head.start_x : r_cur_x;
        eff_cy    = first_now ? i_head.start_y : r_cur_y;
        eff_lines = first_now ? 16'd1 : r_lines;
        last      = (i_head.count == 2'd0) || (r_idx == i_head.count - 2'd1);
        o_pop     = adv && last;
    end

    // Placement of the current code point
    always_comb begin
        cp         = i_head.cp[r_idx];
        is_lf      = (cp == utl_pkg::CP_LF);
        sum_x      = {{2{eff_cx[15]}}, eff_cx} + 18'(cw);
        wrap_hit   = !is_lf && (i_wrap_limit != 15'd0) && (eff_cx > eff_ox)
                     && (sum_x > $signed({3'b000, i_wrap_limit}));
        y_bump     = f_sat_add(eff_cy, lh);
        lines_bump = (eff_lines == 16'hFFFF) ? eff_lines : eff_lines + 16'd1;

        if (is_lf) begin
            kind = utl_pkg::KIND_BREAK;
        end else if (cp >= utl_pkg::CP_PRINT_LO && cp < utl_pkg::CP_PRINT_HI) begin
            kind = utl_pkg::KIND_GLYPH;
        end else if (cp == utl_pkg::CP_CR) begin
            kind = utl_pkg::KIND_BLANK;
        end else begin
            kind = utl_pkg::KIND_BOX;
        end

        px = (is_lf || !wrap_hit) ? eff_cx : eff_ox;
        py = wrap_hit ? y_bump : eff_cy;
    end

    // Next state and output register
    always_comb begin
        n_origin_x  = r_origin_x;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_lines     = r_lines;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        if (adv) begin
            n_origin_x = eff_ox;
            n_idx      = last ? 2'd0 : r_idx + 2'd1;
            if (i_head.count == 2'd0) begin
                n_cur_x = eff_cx;
                n_cur_y = eff_cy;
                n_lines = eff_lines;
            end else begin
                n_cur_x = is_lf ? eff_ox : f_sat_add(px, cw);
                n_cur_y = (is_lf || wrap_hit) ? y_bump : eff_cy;
                n_lines = (is_lf || wrap_hit) ? lines_bump : eff_lines;
                n_out_valid              = 1'b1;
                n_out_word.kind          = kind;
                n_out_word.code_point    = cp;
                n_out_word.pos_x         = px;
                n_out_word.pos_y         = is_lf ? eff_cy : py;
                n_out_word.cell_w        = is_lf ? 11'd0 : f_sat11(cw);
                n_out_word.cell_h        = f_sat11(lh);
                n_out_word.line_count    = (is_lf || wrap_hit) ? lines_bump : eff_lines;
                n_out_word.end_of_string = i_head.final_byte && last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_lines     <= 16'd1;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_origin_x  <= n_origin_x;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_lines     <= n_lines;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

endmodule

[design/utf8_text_cursor_layout.sv]
// Top level: UTF-8 byte decoder with fixed-cell text layout and configuration registers.
//
// Input channel: one byte word per handshake (i_in_valid / o_in_ready) with first and
// final_byte markers and the text origin. Output channel: one draw command word per
// handshake (o_out_valid / i_out_ready). Configuration: a write channel of index and data,
// always ready; write it only while the block is idle.
// Throughput: one byte per cycle while the queue has room. The back end places one code point
// per cycle while its output register is free or being taken, so a final byte that flushes a
// cut-off sequence gives a burst of up to three code points; the decoded-group queue between
// front and back absorbs that burst. A result word for a taken byte passes through the queue
// and then the output register. A byte that only extends a pending sequence gives no word.
// Reset (synchronous, active low) empties the queue, drops held bytes, sets the cursor
// and origin to zero, the line count to one, wrap_limit to zero and scale to one.
// When the receiver stalls the output register holds its word, the back end stops, the
// queue fills and o_in_ready falls once it is full.
module utf8_text_cursor_layout #(
    parameter int CELL_WIDTH  = utl_pkg::CELL_WIDTH_DFLT,
    parameter int CELL_HEIGHT = utl_pkg::CELL_HEIGHT_DFLT,
    parameter int QUEUE_DEPTH = utl_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  utl_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output utl_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [utl_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [utl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [14:0]        r_wrap_limit;
    logic [7:0]         r_scale;

    logic               q_ready;
    logic               push;
    utl_pkg::t_cp_group push_group;
    logic               head_valid;
    utl_pkg::t_cp_group head;
    logic               pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; the color indices are not stored in this block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_limit <= 15'd0;
            r_scale      <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                utl_pkg::REG_WRAP_LIMIT: r_wrap_limit <= i_cfg_data[14:0];
                utl_pkg::REG_SCALE:      r_scale      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    utl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_group    (push_group)
    );

    utl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_group      (push_group),
        .o_ready      (q_ready),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    utl_back #(
        .CELL_WIDTH  (CELL_WIDTH),
        .CELL_HEIGHT (CELL_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_wrap_limit (r_wrap_limit),
        .i_scale      (r_scale),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

endmodule

[verif/utf8_text_cursor_layout_checker.sv]
// Checker of the text cursor layout block: predicts every draw command word and compares it.
module utf8_text_cursor_layout_checker
    import utl_pkg::*;
#(
    parameter int CELL_WIDTH  = CELL_WIDTH_DFLT,
    parameter int CELL_HEIGHT = CELL_HEIGHT_DFLT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  t_in_word               i_in_word,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_out_word              i_out_word,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    // Register copies; the colors are kept but not used in the prediction
    logic [14:0] wrap_limit;
    logic [7:0]  scale;
    logic [15:0] fg_color;
    logic [15:0] bg_color;

    // Decoder and cursor state
    logic [7:0]  held_bytes [3];
    int          held_count;
    int          bytes_needed;
    int          origin_x;
    int          cursor_x;
    int          cursor_y;
    int          lines_used;

    // Draw commands still owed by the block, oldest first
    t_out_word   expected_cmds [$];

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic logic [10:0] clamp11(input int v);
        return (v > 2047) ? 11'd2047 : 11'(v);
    endfunction

    // Continuation bytes that a lead byte asks for; zero for single bytes
    function automatic int seq_tail(input logic [7:0] c);
        if (c < LEAD_ASCII_LIM) return 0;
        if ((c & LEAD2_MASK) == LEAD2_PAT) return 1;
        if ((c & LEAD3_MASK) == LEAD3_PAT) return 2;
        if ((c & LEAD4_MASK) == LEAD4_PAT) return 3;
        return 0;
    endfunction

    function automatic string show(input t_out_word w);
        return $sformatf("kind=%0d cp=%h x=%0d y=%0d w=%0d h=%0d lines=%0d eos=%0d",
                         w.kind, w.code_point, w.pos_x, w.pos_y, w.cell_w, w.cell_h,
                         w.line_count, w.end_of_string);
    endfunction

    task automatic new_line(input int line_h);
        cursor_x = origin_x;
        cursor_y = clamp16(cursor_y + line_h);
        if (lines_used < 65535) lines_used++;
    endtask

    // Places one code point and queues the command it should produce
    task automatic lay_out(input logic [CP_W-1:0] cp, input logic eos);
        int        cw;
        int        lh;
        t_out_word cmd;
        cw = CELL_WIDTH * int'(scale);
        lh = CELL_HEIGHT * int'(scale);
        if (cp == CP_LF) begin
            cmd.kind   = KIND_BREAK;
            cmd.pos_x  = 16'(cursor_x);
            cmd.pos_y  = 16'(cursor_y);
            cmd.cell_w = '0;
            new_line(lh);
        end else begin
            // wrap only once the cursor has left the origin
            if (wrap_limit != '0 && cursor_x > origin_x && cursor_x + cw > int'(wrap_limit))
                new_line(lh);
            if (cp >= CP_PRINT_LO && cp < CP_PRINT_HI) cmd.kind = KIND_GLYPH;
            else if (cp == CP_CR) cmd.kind = KIND_BLANK;
            else cmd.kind = KIND_BOX;
            cmd.pos_x  = 16'(cursor_x);
            cmd.pos_y  = 16'(cursor_y);
            cmd.cell_w = clamp11(cw);
            cursor_x   = clamp16(cursor_x + cw);
        end
        cmd.code_point    = cp;
        cmd.cell_h        = clamp11(lh);
        cmd.line_count    = 16'(lines_used);
        cmd.end_of_string = eos;
        expected_cmds.push_back(cmd);
    endtask

    // One accepted byte: hold it or decode everything held so far
    task automatic take_byte(input t_in_word w);
        logic [7:0]      bytes_in [4];
        logic [CP_W-1:0] cps [MAX_CP];
        logic [7:0]      c;
        logic [CP_W-1:0] cp;
        int              hc;
        int              n;
        int              need;
        int              pos;
        int              tail;
        int              k;
        if (w.first) begin
            origin_x     = int'($signed(w.start_x));
            cursor_x     = origin_x;
            cursor_y     = int'($signed(w.start_y));
            lines_used   = 1;
            held_count   = 0;
            bytes_needed = 0;
        end
        hc = held_count;
        for (int i = 0; i < hc; i++) bytes_in[i] = held_bytes[i];
        bytes_in[hc] = w.in_byte;
        n    = hc + 1;
        need = (hc == 0) ? seq_tail(w.in_byte) : bytes_needed;

        if (!w.final_byte && n < need + 1) begin
            if (hc < 3) begin
                held_bytes[hc] = w.in_byte;
                held_count     = hc + 1;
            end
            if (hc == 0) bytes_needed = need;
            return;
        end

        held_count   = 0;
        bytes_needed = 0;
        // a cut-off sequence gives its lead alone, then the rest is decoded again
        pos = 0;
        k   = 0;
        while (pos < n && k < MAX_CP) begin
            c    = bytes_in[pos];
            pos  = pos + 1;
            tail = seq_tail(c);
            cp   = CP_W'(c);
            if (tail > 0 && pos + tail <= n) begin
                case (tail)
                    1:       cp = CP_W'(c & 8'h1F);
                    2:       cp = CP_W'(c & 8'h0F);
                    default: cp = CP_W'(c & 8'h07);
                endcase
                for (int j = 0; j < tail; j++) begin
                    cp  = {cp[CP_W-7:0], bytes_in[pos][5:0]};
                    pos = pos + 1;
                end
            end
            cps[k] = cp;
            k      = k + 1;
        end
        for (int i = 0; i < k; i++) lay_out(cps[i], w.final_byte && i == k - 1);
    endtask

    task automatic flag(input string msg);
        if (o_fail_count < 10) $display("%t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_cmd(input t_out_word got);
        t_out_word want;
        string     bad;
        if (expected_cmds.size() == 0) begin
            flag($sformatf("draw word with none expected: %s", show(got)));
            return;
        end
        want = expected_cmds.pop_front();
        bad  = "";
        if (got.kind !== want.kind) bad = {bad, " kind"};
        if (got.code_point !== want.code_point) bad = {bad, " code_point"};
        if (got.pos_x !== want.pos_x) bad = {bad, " pos_x"};
        if (got.pos_y !== want.pos_y) bad = {bad, " pos_y"};
        if (got.cell_w !== want.cell_w) bad = {bad, " cell_w"};
        if (got.cell_h !== want.cell_h) bad = {bad, " cell_h"};
        if (got.line_count !== want.line_count) bad = {bad, " line_count"};
        if (got.end_of_string !== want.end_of_string) bad = {bad, " end_of_string"};
        if (bad != "")
            flag($sformatf("draw word mismatch on%s\n  expected %s\n  actual   %s",
                           bad, show(want), show(got)));
    endtask

    // Everything is sampled at the same edge the block samples
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wrap_limit   = '0;
            scale        = 8'd1;
            fg_color     = 16'hFFFF;
            bg_color     = '0;
            for (int i = 0; i < 3; i++) held_bytes[i] = '0;
            held_count   = 0;
            bytes_needed = 0;
            origin_x     = 0;
            cursor_x     = 0;
            cursor_y     = 0;
            lines_used   = 1;
            expected_cmds.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WRAP_LIMIT: wrap_limit = i_cfg_data[14:0];
                    REG_SCALE:      scale      = i_cfg_data[7:0];
                    REG_FG_COLOR:   fg_color   = i_cfg_data;
                    REG_BG_COLOR:   bg_color   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) take_byte(i_in_word);
            if (i_out_valid && i_out_ready) check_cmd(i_out_word);
        end
        o_pending = expected_cmds.size();
    end

endmodule

[verif/utf8_text_cursor_layout_tb.sv]
// Testbench top of the text cursor layout block: byte strings, register writes and the verdict.
module utf8_text_cursor_layout_tb;
    import utl_pkg::*;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    t_in_word               in_word   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_out_word              out_word;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int                     fail_count;
    int                     pending;
    logic                   no_gaps   = 1'b0;
    int                     bytes_sent = 0;

    utf8_text_cursor_layout i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    utf8_text_cursor_layout_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stalls except in steady stretches
    always @(negedge clk) begin
        out_ready = no_gaps || ($urandom_range(99) >= 38);
    end

    // Sends one byte word, with random idling in front of it unless no_gaps is set
    task automatic send_byte(input logic [7:0] b, input logic first, input logic fin,
                             input logic [15:0] sx, input logic [15:0] sy);
        while (!no_gaps && $urandom_range(99) < 38) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_word.in_byte    = b;
        in_word.first      = first;
        in_word.final_byte = fin;
        in_word.start_x    = sx;
        in_word.start_y    = sy;
        in_valid           = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [15:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Holds the sender until every owed word is out, then lets the block go quiet
    task automatic settle(input int quiet_cycles);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (quiet_cycles) @(negedge clk);
    endtask

    task automatic set_regs(input logic [15:0] wrap, input logic [15:0] scl,
                            input logic [15:0] fg, input logic [15:0] bg);
        write_reg(REG_WRAP_LIMIT, wrap);
        write_reg(REG_SCALE, scl);
        write_reg(REG_FG_COLOR, fg);
        write_reg(REG_BG_COLOR, bg);
    endtask

    // One random string: mostly well-formed characters, some noise, sometimes cut short
    task automatic send_text(input int n_chars);
        logic [7:0]  text [$];
        logic [15:0] sx;
        logic [15:0] sy;
        logic        first_flag;
        int          roll;
        int          tail;
        for (int i = 0; i < n_chars; i++) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                text.push_back(8'($urandom_range(8'h20, 8'h7F)));
            end else if (roll < 55) begin
                text.push_back($urandom_range(1) ? 8'h0A : 8'h0D);
            end else if (roll < 85) begin
                tail = $urandom_range(1, 3);
                case (tail)
                    1:       text.push_back(8'hC0 | 8'($urandom_range(8'h1F)));
                    2:       text.push_back(8'hE0 | 8'($urandom_range(8'h0F)));
                    default: text.push_back(8'hF0 | 8'($urandom_range(8'h07)));
                endcase
                repeat (tail) text.push_back(8'h80 | 8'($urandom_range(8'h3F)));
            end else begin
                text.push_back(8'($urandom));
            end
        end
        if ($urandom_range(3) == 0 && text.size() > 1) void'(text.pop_back());

        first_flag = ($urandom_range(9) != 0);
        if ($urandom_range(4) == 0) begin
            sx = 16'($urandom);
            sy = 16'($urandom);
        end else begin
            sx = 16'(int'($urandom_range(300)) - 150);
            sy = 16'(int'($urandom_range(300)) - 150);
        end
        for (int i = 0; i < text.size(); i++) begin
            // now and then drain the block in the middle of a string
            if (i > 0 && !no_gaps && $urandom_range(15) == 0) settle(0);
            if (i == 0 && first_flag)
                send_byte(text[i], 1'b1, text.size() == 1, sx, sy);
            else
                send_byte(text[i], 1'b0, i == text.size() - 1, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic random_phase(input int n_bytes);
        int base;
        base = bytes_sent;
        while (bytes_sent - base < n_bytes) send_text($urandom_range(1, 6));
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset register values
        send_byte(8'h41, 1'b1, 1'b0, 16'h8000, 16'h7FFF);
        send_byte(8'h00, 1'b0, 1'b0, '0, '0);
        send_byte(8'h0D, 1'b0, 1'b0, '0, '0);
        send_byte(8'h0A, 1'b0, 1'b0, '0, '0);
        send_byte(8'h7F, 1'b0, 1'b0, '0, '0);
        send_byte(8'hC3, 1'b0, 1'b0, '0, '0);
        send_byte(8'hA9, 1'b0, 1'b0, '0, '0);
        send_byte(8'hE2, 1'b0, 1'b0, '0, '0);
        send_byte(8'h82, 1'b0, 1'b0, '0, '0);
        send_byte(8'hAC, 1'b0, 1'b0, '0, '0);
        send_byte(8'hF0, 1'b0, 1'b0, '0, '0);
        send_byte(8'h9F, 1'b0, 1'b0, '0, '0);
        send_byte(8'h98, 1'b0, 1'b0, '0, '0);
        send_byte(8'h80, 1'b0, 1'b0, '0, '0);
        // stray continuation and bytes that can never lead
        send_byte(8'h80, 1'b0, 1'b0, '0, '0);
        send_byte(8'hFF, 1'b0, 1'b0, '0, '0);
        send_byte(8'hF8, 1'b0, 1'b0, '0, '0);
        // sequence cut off by the end of the string
        send_byte(8'hE2, 1'b0, 1'b0, '0, '0);
        send_byte(8'h82, 1'b0, 1'b1, '0, '0);
        // bytes after the end continue the layout
        send_byte(8'h42, 1'b0, 1'b0, '0, '0);
        send_byte(8'hF0, 1'b0, 1'b0, '0, '0);
        send_byte(8'h9F, 1'b0, 1'b0, '0, '0);
        send_byte(8'h98, 1'b0, 1'b1, '0, '0);
        // new string drops a pending lead byte; cursor saturates at the right edge
        send_byte(8'hC3, 1'b0, 1'b0, '0, '0);
        send_byte(8'h5A, 1'b1, 1'b1, 16'h7FFF, 16'h8000);
        settle(6);

        // Widest wrap limit and largest cells
        set_regs(16'h7FFF, 16'd255, 16'h0000, 16'hFFFF);
        random_phase(15);
        settle(6);

        // Narrow wrap, unit cells, no idling on either side
        set_regs(16'd40, 16'd1, 16'($urandom), 16'($urandom));
        no_gaps = 1'b1;
        random_phase(30);
        no_gaps = 1'b0;
        settle(6);

        // Zero-size cells against the smallest wrap limit
        set_regs(16'd1, 16'd0, 16'($urandom), 16'($urandom));
        random_phase(15);
        settle(6);

        // Random moderate settings
        set_regs(16'($urandom_range(20, 200)), 16'($urandom_range(2, 4)),
                 16'($urandom), 16'($urandom));
        random_phase(15);

        settle(20);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
